FILE: rtl/swab_pkg.sv
// Shared constants, codes and types of the sliding window airtime budget.
package swab_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DATA_W = 32;
    localparam int DIV_W  = DATA_W + 1;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_SLOTS  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic              clr;
        logic              wen;
        logic [SLOT_W-1:0] idx;
        logic [DATA_W-1:0] wdata;
    } t_ring_cmd;

endpackage

FILE: rtl/swab_if.sv
// Handshake channels carrying request items in and result items out.
interface swab_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] air_ms;

    modport source (output valid, op, now, air_ms, input ready);
    modport sink   (input valid, op, now, air_ms, output ready);
endinterface

interface swab_out_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [31:0] used_ms;

    modport source (output valid, allowed, used_ms, input ready);
    modport sink   (input valid, allowed, used_ms, output ready);
endinterface

FILE: rtl/swab_div.sv
// Restoring divider that produces one quotient bit per cycle.
module swab_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swab_pkg::t_div_req  i_req,
    output swab_pkg::t_div_rsp  o_rsp
);
    import swab_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;

    logic [CNT_W:0]    trial;
    logic              ge;
    logic [CNT_W:0]    diff;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[DATA_W-1:0];

endmodule

FILE: rtl/swab_ring.sv
// Ring of per-slot airtime totals with a single access port and a bulk clear.
module swab_ring (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  swab_pkg::t_ring_cmd         i_cmd,
    output logic [swab_pkg::DATA_W-1:0] o_rdata
);
    import swab_pkg::*;

    logic [DATA_W-1:0] r_slot [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cmd.wen) begin
            r_slot[i_cmd.idx] <= i_cmd.wdata;
        end
    end

    assign o_rdata = r_slot[i_cmd.idx];

endmodule

FILE: rtl/sliding_window_airtime_budget.sv
// Top level of the sliding window airtime budget: sequencer, ledger state and result register.
//
// Usage: request items arrive on i_in (op, now, air_ms) with a valid/ready
// handshake; each item gives exactly one result item on o_out (allowed, used_ms).
// Window, limit and slot count are written through i_cfg_we/i_cfg_idx/i_cfg_data
// and take effect at the next start item.
// Steps: an unused op, a check on a disabled ledger or a record that does
// nothing goes straight to ST_RESP. A check or record on an enabled ledger goes
// from ST_AGE_CHK to ST_FIN when the whole window has expired, otherwise through
// ST_AGE_STEP and one ST_AGE_DROP per slot the ring advances (at most SLOTS - 1)
// to ST_FIN and ST_RESP. A start item with a nonzero window and slot count waits
// in ST_DIV for the divider, which yields the 33 quotient bits of the slot length
// one per cycle. One item is in work at a time: i_in.ready is high only while
// the sequencer is idle, so a new item is taken only once the last has left ST_RESP.
// The result sits in an output register; a new item is taken while it waits,
// and the sequencer holds its next result until the receiver takes the first.
// Synchronous reset clears the ledger (disabled), the config registers and o_out.valid.
module sliding_window_airtime_budget (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    swab_in_if.sink              i_in,
    swab_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import swab_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV      = 3'd1;
    localparam logic [2:0] ST_AGE_CHK  = 3'd2;
    localparam logic [2:0] ST_AGE_STEP = 3'd3;
    localparam logic [2:0] ST_AGE_DROP = 3'd4;
    localparam logic [2:0] ST_FIN      = 3'd5;
    localparam logic [2:0] ST_RESP     = 3'd6;

    logic [2:0]        r_state;

    logic [DATA_W-1:0] r_cfg_win;
    logic [DATA_W-1:0] r_cfg_lim;
    logic [7:0]        r_cfg_cnt;

    logic [1:0]        r_op;
    logic [DATA_W-1:0] r_now;
    logic [DATA_W-1:0] r_air;

    logic [DATA_W-1:0] r_win;
    logic [DATA_W-1:0] r_lim;
    logic [DATA_W-1:0] r_used;
    logic [DATA_W-1:0] r_start;
    logic [DATA_W-1:0] r_len;
    logic [DATA_W-1:0] r_elapsed;
    logic [SLOT_W-1:0] r_cur;
    logic [CNT_W-1:0]  r_active;
    logic              r_allowed;

    logic              r_out_valid;
    logic              r_out_allowed;
    logic [DATA_W-1:0] r_out_used;

    logic              in_acc;
    logic              out_free;
    logic [CNT_W-1:0]  clamp_n;
    logic [DATA_W-1:0] elapsed;
    logic              expired;
    logic [CNT_W-1:0]  cur_inc;
    logic [SLOT_W-1:0] cur_next;
    logic [DATA_W-1:0] rdata;
    t_ring_cmd         ring_cmd;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign clamp_n  = (r_cfg_cnt > 8'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(r_cfg_cnt);
    assign elapsed  = r_now - r_start;
    assign expired  = (elapsed >= r_win);
    assign cur_inc  = CNT_W'(r_cur) + 1'b1;
    assign cur_next = (cur_inc == r_active) ? '0 : cur_inc[SLOT_W-1:0];

    always_comb begin
        ring_cmd.clr   = (r_state == ST_IDLE && in_acc && i_in.op == OP_START)
                      || (r_state == ST_AGE_CHK && expired);
        ring_cmd.wen   = (r_state == ST_AGE_DROP) || (r_state == ST_FIN && r_op == OP_RECORD);
        ring_cmd.idx   = r_cur;
        ring_cmd.wdata = (r_state == ST_AGE_DROP) ? '0 : rdata + r_air;
    end

    // Ceiling division: the slot count minus one is added before dividing.
    always_comb begin
        div_req.start    = (r_state == ST_IDLE) && in_acc && (i_in.op == OP_START)
                        && (r_cfg_win != '0) && (r_cfg_cnt != '0);
        div_req.dividend = {1'b0, r_cfg_win} + DIV_W'(clamp_n) - 1'b1;
        div_req.divisor  = clamp_n;
    end

    swab_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .o_rdata (rdata)
    );

    swab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win <= '0;
            r_cfg_lim <= '0;
            r_cfg_cnt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW: r_cfg_win <= i_cfg_data;
                REG_LIMIT:  r_cfg_lim <= i_cfg_data;
                REG_SLOTS:  r_cfg_cnt <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_win     <= '0;
            r_lim     <= '0;
            r_used    <= '0;
            r_start   <= '0;
            r_len     <= '0;
            r_cur     <= '0;
            r_active  <= '0;
            r_allowed <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op      <= i_in.op;
                        r_now     <= i_in.now;
                        r_air     <= i_in.air_ms;
                        r_allowed <= 1'b0;
                        r_state   <= ST_RESP;
                        case (i_in.op)
                            OP_CHECK: begin
                                if (r_active == '0) begin
                                    r_allowed <= 1'b1;
                                end else begin
                                    r_state <= ST_AGE_CHK;
                                end
                            end
                            OP_RECORD: begin
                                if (r_active != '0 && i_in.air_ms != '0) begin
                                    r_state <= ST_AGE_CHK;
                                end
                            end
                            OP_START: begin
                                r_win    <= '0;
                                r_lim    <= '0;
                                r_used   <= '0;
                                r_start  <= '0;
                                r_len    <= '0;
                                r_cur    <= '0;
                                r_active <= '0;
                                if (div_req.start) begin
                                    r_win    <= r_cfg_win;
                                    r_lim    <= r_cfg_lim;
                                    r_active <= clamp_n;
                                    r_start  <= i_in.now;
                                    r_state  <= ST_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_len   <= div_rsp.quotient;
                        r_state <= ST_RESP;
                    end
                end
                ST_AGE_CHK: begin
                    if (expired) begin
                        r_used  <= '0;
                        r_cur   <= '0;
                        r_start <= r_now;
                        r_state <= ST_FIN;
                    end else begin
                        r_elapsed <= elapsed;
                        r_state   <= ST_AGE_STEP;
                    end
                end
                // One slot length is peeled off the elapsed time per pass.
                ST_AGE_STEP: begin
                    if (r_elapsed >= r_len) begin
                        r_elapsed <= r_elapsed - r_len;
                        r_start   <= r_start + r_len;
                        r_cur     <= cur_next;
                        r_state   <= ST_AGE_DROP;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_AGE_DROP: begin
                    r_used  <= r_used - rdata;
                    r_state <= ST_AGE_STEP;
                end
                ST_FIN: begin
                    if (r_op == OP_CHECK) begin
                        r_allowed <= ({1'b0, r_used} + {1'b0, r_air}) <= {1'b0, r_lim};
                    end else begin
                        r_used <= r_used + r_air;
                    end
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && out_free) begin
            r_out_allowed <= r_allowed;
            r_out_used    <= r_used;
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.allowed = r_out_allowed;
    assign o_out.used_ms = r_out_used;

`ifndef SYNTHESIS
    a_cur_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != '0) |-> (CNT_W'(r_cur) < r_active))
        else $error("current slot outside the active ring");

    a_active_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CNT_W'(SLOTS))
        else $error("active slot count above the ring size");

    a_len_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_active != '0) |-> (r_len != '0))
        else $error("enabled ledger has a zero slot length");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("result item raised outside the response state");
`endif

endmodule
